/* hw/rtl/ppe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_pkg: shared types and constants for the peak prominence engine
// Payload structs, action and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package ppe_pkg;

	localparam int MaxPoints = 4096;
	localparam int MaxPeaks  = 64;
	localparam int PtAw      = $clog2(MaxPoints);
	localparam int PkAw      = $clog2(MaxPeaks);
	localparam int PtCw      = PtAw + 1;
	localparam int PkCw      = PkAw + 1;
	localparam int MinPoints = 3;

	localparam logic [1:0] ACT_POINT = 2'd0;
	localparam logic [1:0] ACT_PEAK  = 2'd1;
	localparam logic [1:0] ACT_RUN   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FEW      = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic REG_VALLEY_MODE = 1'b0;
	localparam logic REG_ZERO_TOL    = 1'b1;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        x_position;
		logic signed [31:0] intensity;
	} in_item_t;

	typedef struct packed {
		logic [31:0] prominence;
		logic [5:0]  peak_number;
		logic [1:0]  status;
		logic        last;
	} out_item_t;

	// controller -> datapath commands
	typedef struct packed {
		logic            ld_point;    // write point store at point count
		logic            ld_peak;     // write peak store at peak count
		logic            clr_counts;
		logic            pk_rd;       // read peak at cur_i (target)
		logic            set_target;  // latch target from peak read data
		logic            scan_rd;     // read peak at scan_j
		logic            scan_acc;    // fold peak read data into bounds
		logic            ends_rd;     // read first/last point
		logic            ends_lat;
		logic            pt_rd;       // read point at scan_k
		logic            pt_acc;      // fold point read data into minima
		logic            emit;        // present result for cur_i
		logic            emit_err;
		logic [PkAw-1:0] cur_i;
		logic [PkAw-1:0] scan_j;
		logic [PtAw-1:0] scan_k;
		logic            first_last;  // ends_lat: 0 first point, 1 last
		logic            is_last;
	} ppe_cmd_t;

	typedef struct packed {
		logic [PtCw-1:0] point_count;
		logic [PkCw-1:0] peak_count;
	} ppe_stat_t;

endpackage

/* hw/rtl/ppe_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_datapath: stores, bound search and span minima
// Holds point and peak memories, counts, and the per-peak arithmetic.
// ----------------------------------------------------------------------------
module ppe_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ppe_pkg::in_item_t   item,
	input  ppe_pkg::ppe_cmd_t   cmd,
	input  logic                valley_mode,
	input  logic [30:0]         zero_tolerance,
	output ppe_pkg::ppe_stat_t  stat,
	output logic                result_valid,
	output ppe_pkg::out_item_t  result
);
	import ppe_pkg::*;

	logic [31:0] pt_x_mem [MaxPoints];
	logic [31:0] pt_y_mem [MaxPoints];
	logic [31:0] pk_x_mem [MaxPeaks];
	logic [31:0] pk_y_mem [MaxPeaks];

	logic [PtCw-1:0] pt_cnt_q;
	logic [PkCw-1:0] pk_cnt_q;
	logic            ovf_q;

	logic [31:0]        ptx_rd_q, pkx_rd_q;
	logic signed [31:0] pty_rd_q, pky_rd_q;
	logic [PkAw-1:0]    pk_addr;

	logic [31:0]        xp_q, lb_q, rb_q;
	logic signed [31:0] yp_q, lmin_q, rmin_q;
	logic               has_l_q, has_r_q, lfound_q, rfound_q;
	logic               valid_q;
	out_item_t          res_q;

	logic signed [31:0] ref_v;
	logic signed [32:0] prom;

	assign pk_addr = cmd.pk_rd ? cmd.cur_i : cmd.scan_j;

	// memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.ld_point && pt_cnt_q < PtCw'(MaxPoints)) begin
			pt_x_mem[pt_cnt_q[PtAw-1:0]] <= item.x_position;
			pt_y_mem[pt_cnt_q[PtAw-1:0]] <= item.intensity;
		end
		if (cmd.ld_peak && pk_cnt_q < PkCw'(MaxPeaks)) begin
			pk_x_mem[pk_cnt_q[PkAw-1:0]] <= item.x_position;
			pk_y_mem[pk_cnt_q[PkAw-1:0]] <= item.intensity;
		end
		ptx_rd_q <= pt_x_mem[cmd.scan_k];
		pty_rd_q <= pt_y_mem[cmd.scan_k];
		pkx_rd_q <= pk_x_mem[pk_addr];
		pky_rd_q <= pk_y_mem[pk_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_cnt_q <= '0;
			pk_cnt_q <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.clr_counts) begin
			pt_cnt_q <= '0;
			pk_cnt_q <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.ld_point) begin
			if (pt_cnt_q < PtCw'(MaxPoints)) pt_cnt_q <= pt_cnt_q + 1'b1;
			else ovf_q <= 1'b1;
		end else if (cmd.ld_peak) begin
			if (pk_cnt_q < PkCw'(MaxPeaks)) pk_cnt_q <= pk_cnt_q + 1'b1;
			else ovf_q <= 1'b1;
		end
	end

	assign stat.point_count = pt_cnt_q;
	assign stat.peak_count  = pk_cnt_q;

	// bound search and span minima
	always_ff @(posedge clk) begin
		if (cmd.set_target) begin
			xp_q     <= pkx_rd_q;
			yp_q     <= pky_rd_q;
			has_l_q  <= 1'b0;
			has_r_q  <= 1'b0;
			lfound_q <= 1'b0;
			rfound_q <= 1'b0;
			lmin_q   <= pky_rd_q;
			rmin_q   <= pky_rd_q;
		end
		if (cmd.scan_acc && pky_rd_q > yp_q) begin
			if (pkx_rd_q < xp_q && (!has_l_q || pkx_rd_q > lb_q)) begin
				lb_q    <= pkx_rd_q;
				has_l_q <= 1'b1;
			end
			if (pkx_rd_q > xp_q && (!has_r_q || pkx_rd_q < rb_q)) begin
				rb_q    <= pkx_rd_q;
				has_r_q <= 1'b1;
			end
		end
		if (cmd.ends_lat) begin
			if (!cmd.first_last && !has_l_q) lb_q <= ptx_rd_q;
			if (cmd.first_last && !has_r_q)  rb_q <= ptx_rd_q;
		end
		if (cmd.pt_acc) begin
			if (ptx_rd_q >= lb_q && ptx_rd_q <= xp_q
			    && (!lfound_q || pty_rd_q < lmin_q)) begin
				lmin_q   <= pty_rd_q;
				lfound_q <= 1'b1;
			end
			if (ptx_rd_q >= xp_q && ptx_rd_q <= rb_q
			    && (!rfound_q || pty_rd_q < rmin_q)) begin
				rmin_q   <= pty_rd_q;
				rfound_q <= 1'b1;
			end
		end
	end

	always_comb begin
		if (!valley_mode) ref_v = (lmin_q > rmin_q) ? lmin_q : rmin_q;
		else              ref_v = (lmin_q < rmin_q) ? lmin_q : rmin_q;
		prom = 33'(yp_q) - 33'(ref_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit || cmd.emit_err;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			res_q.prominence  <= '0;
			res_q.peak_number <= '0;
			res_q.status      <= ST_FEW;
			res_q.last        <= 1'b1;
		end else if (cmd.emit) begin
			res_q.prominence  <= (prom <= $signed({2'b00, zero_tolerance}))
			                     ? 32'd0 : prom[31:0];
			res_q.peak_number <= 6'(cmd.cur_i);
			res_q.status      <= ovf_q ? ST_OVERFLOW : ST_OK;
			res_q.last        <= cmd.is_last;
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pt_cnt_q <= PtCw'(MaxPoints) && pk_cnt_q <= PkCw'(MaxPeaks))
		else $error("count past capacity");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_counts |=> pt_cnt_q == '0 && pk_cnt_q == '0 && !ovf_q)
		else $error("counts not cleared");
	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && cmd.emit_err))
		else $error("double emit");
endmodule

/* hw/rtl/ppe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_ctrl: run sequencer
// Walks peaks, the bound scan over all peaks and the point scan per peak.
// ----------------------------------------------------------------------------
module ppe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         action,
	input  ppe_pkg::ppe_stat_t stat,
	output logic               busy,
	output ppe_pkg::ppe_cmd_t  cmd
);
	import ppe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_TGT_RD, S_TGT_LAT, S_SCAN, S_SCAN_LAST, S_ENDS_F, S_ENDS_L,
		S_ENDS_L2, S_PTS, S_PTS_LAST, S_EMIT, S_DONE
	} state_t;

	state_t          state_q;
	logic [PkAw-1:0] i_q, j_q;
	logic [PtAw-1:0] k_q;
	logic            busy_q;
	logic            accept, run_go;
	logic [PkCw-1:0] i_next;

	assign accept = start && !busy_q;
	assign run_go = accept && action == ACT_RUN;
	assign busy   = busy_q;
	assign i_next = PkCw'(i_q) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (run_go) begin
						busy_q <= 1'b1;
						i_q    <= '0;
						if (stat.point_count < PtCw'(MinPoints) || stat.peak_count == '0)
							state_q <= S_DONE;
						else
							state_q <= S_TGT_RD;
					end
				end
				S_TGT_RD:  state_q <= S_TGT_LAT;
				S_TGT_LAT: begin
					j_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// read issued at j; fold arrives next cycle
					if (PkCw'(j_q) + 1'b1 == stat.peak_count) state_q <= S_SCAN_LAST;
					else j_q <= j_q + 1'b1;
				end
				S_SCAN_LAST: state_q <= S_ENDS_F;
				S_ENDS_F:    state_q <= S_ENDS_L;
				S_ENDS_L:    state_q <= S_ENDS_L2;
				S_ENDS_L2: begin
					k_q     <= '0;
					state_q <= S_PTS;
				end
				S_PTS: begin
					if (PtCw'(k_q) + 1'b1 == stat.point_count) state_q <= S_PTS_LAST;
					else k_q <= k_q + 1'b1;
				end
				S_PTS_LAST: state_q <= S_EMIT;
				S_EMIT: begin
					if (i_next == stat.peak_count) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_TGT_RD;
					end
				end
				S_DONE: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.cur_i      = i_q;
		cmd.scan_j     = j_q;
		cmd.is_last    = i_next == stat.peak_count;
		cmd.ld_point   = accept && action == ACT_POINT;
		cmd.ld_peak    = accept && action == ACT_PEAK;
		cmd.scan_k     = k_q;
		case (state_q)
			S_IDLE: begin
				cmd.emit_err = run_go && stat.point_count < PtCw'(MinPoints);
			end
			S_TGT_RD:  cmd.pk_rd = 1'b1;
			S_TGT_LAT: cmd.set_target = 1'b1;
			S_SCAN: begin
				cmd.scan_rd  = 1'b1;
				cmd.scan_acc = j_q != '0;
			end
			S_SCAN_LAST: cmd.scan_acc = 1'b1;
			S_ENDS_F: begin
				cmd.scan_k = '0;
			end
			S_ENDS_L: begin
				cmd.ends_lat   = 1'b1;
				cmd.first_last = 1'b0;
				cmd.scan_k     = PtAw'(stat.point_count - 1'b1);
			end
			S_ENDS_L2: begin
				cmd.ends_lat   = 1'b1;
				cmd.first_last = 1'b1;
			end
			S_PTS: begin
				cmd.pt_rd  = 1'b1;
				cmd.pt_acc = k_q != '0;
			end
			S_PTS_LAST: cmd.pt_acc = 1'b1;
			S_EMIT:     cmd.emit = 1'b1;
			S_DONE:     cmd.clr_counts = 1'b1;
			default: ;
		endcase
		cmd.ends_rd = state_q == S_ENDS_F || state_q == S_ENDS_L;
	end

	a_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !busy_q)
		else $error("busy in idle");
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		run_go |=> busy_q)
		else $error("run did not start");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd.ld_point && !cmd.ld_peak)
		else $error("load while busy");
endmodule

/* hw/rtl/peak_prominence_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_prominence_engine: prominence of each loaded peak over a spectrum
// Loads points and peaks, then computes one prominence per peak on run.
// ----------------------------------------------------------------------------
// Loads never raise busy. A run holds busy while, for each peak, the sequencer
// scans the peak store once for the nearest higher neighbors and the point
// store once for both span minima, one memory read per cycle. Results come
// out one per peak on the result strobe, one cycle each; the receiver cannot
// stall.
// A run with fewer than three points gives one error result at once.
module peak_prominence_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ppe_pkg::in_item_t   item,
	output logic                result_valid,
	output ppe_pkg::out_item_t  result,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [30:0]         cfg_data
);
	import ppe_pkg::*;

	ppe_cmd_t    cmd;
	ppe_stat_t   stat;
	logic        valley_mode_q;
	logic [30:0] zero_tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valley_mode_q <= 1'b0;
			zero_tol_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VALLEY_MODE: valley_mode_q <= cfg_data[0];
				REG_ZERO_TOL:    zero_tol_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	ppe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	ppe_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.cmd            (cmd),
		.valley_mode    (valley_mode_q),
		.zero_tolerance (zero_tol_q),
		.stat           (stat),
		.result_valid   (result_valid),
		.result         (result)
	);
endmodule
